@@ src/trle_pkg.sv @@
// ----------------------------------------------------------------------------
// TGA RLE decoder package
// Shared types and constants for the TGA truecolor stream decoder.
// ----------------------------------------------------------------------------
package trle_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_IDSKIP = 3'd1,
        PH_PIXELS = 3'd2,
        PH_RUN    = 3'd3,
        PH_DONE   = 3'd4
    } t_phase;

    // Header byte positions
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    // Header field codes
    localparam logic [7:0] IMG_TYPE_RAW  = 8'd2;
    localparam logic [7:0] IMG_TYPE_RLE  = 8'd10;
    localparam logic [7:0] DEPTH_24      = 8'd24;
    localparam logic [7:0] DEPTH_32      = 8'd32;
    localparam logic [7:0] DESC_FLIP_A   = 8'h00;
    localparam logic [7:0] DESC_FLIP_B   = 8'h08;

    // RLE packet header
    localparam int unsigned PKT_RUN_BIT  = 7;
    localparam logic [7:0]  PKT_CNT_MASK = 8'h7F;

    localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

    // Result status codes
    localparam logic STATUS_PIXEL  = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Position step for one emitted pixel
    typedef struct packed {
        logic [15:0] dest_row;
        logic        last;
        logic [15:0] next_col;
        logic [15:0] next_row;
    } t_pos;

endpackage

@@ src/tga_rle_pixel_decoder.sv @@
// ----------------------------------------------------------------------------
// TGA RLE pixel decoder
// Byte-stream decoder for 24/32-bit truecolor TGA images, raw or RLE.
// ----------------------------------------------------------------------------
// The block takes a TGA file one byte per input item (tuser marks the first
// byte of a file and restarts parsing) and sustains one item per clock. Every
// byte is handled by the parser state, and each result appears in the output
// register in the cycle after its byte; the input stays ready while that
// register is empty or being drained, so throughput is set only by the
// output side. The 18-byte header is checked (colormap type 0, image type 2 or
// 10, depth 24 or 32); a bad header gives one result with status set and all
// other fields zero, then bytes are dropped until the next first byte. After
// the ID field, pixels come out as RGBA with destination row and column, alpha
// 0xFF for 24-bit images, rows flipped when the descriptor is 0x00 or 0x08.
// A run packet emits its first pixel on the byte that completes its color;
// each further pixel of the run consumes one more input item whose data is
// ignored, so the feeder must keep supplying items. tlast marks the final
// pixel; bytes after it are dropped. An image of zero width or height gives
// no results.
// ----------------------------------------------------------------------------
module tga_rle_pixel_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tuser,   // [0] first_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [15:0] row, [31:16] column, [39:32] red,
                                        // [47:40] green, [55:48] blue, [63:56] alpha
    output logic        m_axis_tuser,   // [0] status
    output logic        m_axis_tlast    // last_pixel
);

    // Parser state
    trle_pkg::t_phase r_phase,         n_phase;
    logic [4:0]       r_header_index,  n_header_index;
    logic [7:0]       r_id_skip_left,  n_id_skip_left;
    logic [15:0]      r_image_width,   n_image_width;
    logic [15:0]      r_image_height,  n_image_height;
    logic             r_rle_mode,      n_rle_mode;
    logic             r_alpha_present, n_alpha_present;
    logic             r_flip_rows,     n_flip_rows;
    logic [7:0]       r_packet_left,   n_packet_left;
    logic             r_packet_is_run, n_packet_is_run;
    logic [1:0]       r_byte_in_pixel, n_byte_in_pixel;
    logic [23:0]      r_partial_color, n_partial_color;
    logic [31:0]      r_run_color,     n_run_color;
    logic [15:0]      r_column_count,  n_column_count;
    logic [15:0]      r_row_count,     n_row_count;

    // Output register
    logic             r_out_valid;
    logic [63:0]      r_out_data;
    logic             r_out_status;
    logic             r_out_last;

    // Result of the current item
    logic             res_valid;
    logic             res_status;
    logic [15:0]      res_row;
    logic [15:0]      res_col;
    logic [31:0]      res_rgba;
    logic             res_last;

    logic             in_fire;
    trle_pkg::t_pos   pos;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

    // Position of the pixel at the current scan point
    trle_pixel_pos u_pos (
        .i_col    (r_column_count),
        .i_row    (r_row_count),
        .i_width  (r_image_width),
        .i_height (r_image_height),
        .i_rle    (r_rle_mode),
        .i_flip   (r_flip_rows),
        .o_pos    (pos)
    );

    always_comb begin
        logic [7:0]  b;
        logic [1:0]  final_index;
        logic [31:0] rgba;
        logic        start_pixels;

        b            = s_axis_tdata;
        final_index  = 2'd2;
        rgba         = '0;
        start_pixels = 1'b0;

        // Hold state by default; a first byte restarts from the cleared state
        if (s_axis_tuser) begin
            n_phase         = trle_pkg::PH_HEADER;
            n_header_index  = '0;
            n_id_skip_left  = '0;
            n_image_width   = '0;
            n_image_height  = '0;
            n_rle_mode      = 1'b0;
            n_alpha_present = 1'b0;
            n_flip_rows     = 1'b0;
            n_packet_left   = '0;
            n_packet_is_run = 1'b0;
            n_byte_in_pixel = '0;
            n_partial_color = '0;
            n_run_color     = '0;
            n_column_count  = '0;
            n_row_count     = '0;
        end else begin
            n_phase         = r_phase;
            n_header_index  = r_header_index;
            n_id_skip_left  = r_id_skip_left;
            n_image_width   = r_image_width;
            n_image_height  = r_image_height;
            n_rle_mode      = r_rle_mode;
            n_alpha_present = r_alpha_present;
            n_flip_rows     = r_flip_rows;
            n_packet_left   = r_packet_left;
            n_packet_is_run = r_packet_is_run;
            n_byte_in_pixel = r_byte_in_pixel;
            n_partial_color = r_partial_color;
            n_run_color     = r_run_color;
            n_column_count  = r_column_count;
            n_row_count     = r_row_count;
        end

        res_valid  = 1'b0;
        res_status = trle_pkg::STATUS_PIXEL;
        res_row    = '0;
        res_col    = '0;
        res_rgba   = '0;
        res_last   = 1'b0;

        unique case (n_phase)
            trle_pkg::PH_HEADER: begin
                n_header_index = n_header_index + 5'd1;
                unique case (n_header_index - 5'd1)
                    trle_pkg::HDR_ID_LEN: begin
                        n_id_skip_left = b;
                    end
                    trle_pkg::HDR_CMAP_TYPE: begin
                        if (b != 8'd0) begin
                            res_valid = 1'b1;
                        end
                    end
                    trle_pkg::HDR_IMG_TYPE: begin
                        if (b == trle_pkg::IMG_TYPE_RAW) begin
                            n_rle_mode = 1'b0;
                        end else if (b == trle_pkg::IMG_TYPE_RLE) begin
                            n_rle_mode = 1'b1;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end
                    trle_pkg::HDR_WIDTH_LO:  n_image_width[7:0]   = b;
                    trle_pkg::HDR_WIDTH_HI:  n_image_width[15:8]  = b;
                    trle_pkg::HDR_HEIGHT_LO: n_image_height[7:0]  = b;
                    trle_pkg::HDR_HEIGHT_HI: n_image_height[15:8] = b;
                    trle_pkg::HDR_DEPTH: begin
                        if (b == trle_pkg::DEPTH_24) begin
                            n_alpha_present = 1'b0;
                        end else if (b == trle_pkg::DEPTH_32) begin
                            n_alpha_present = 1'b1;
                        end else begin
                            res_valid = 1'b1;
                        end
                    end
                    trle_pkg::HDR_DESC: begin
                        n_header_index = trle_pkg::HDR_DESC;
                        n_flip_rows    = (b == trle_pkg::DESC_FLIP_A)
                                      || (b == trle_pkg::DESC_FLIP_B);
                        if (n_id_skip_left != 8'd0) begin
                            n_phase = trle_pkg::PH_IDSKIP;
                        end else begin
                            start_pixels = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                // Reject: freeze the index, give a status-only result
                if (res_valid) begin
                    n_header_index = n_header_index - 5'd1;
                    n_phase        = trle_pkg::PH_DONE;
                    res_status     = trle_pkg::STATUS_REJECT;
                end
            end

            trle_pkg::PH_IDSKIP: begin
                n_id_skip_left = n_id_skip_left - 8'd1;
                if (n_id_skip_left == 8'd0) begin
                    start_pixels = 1'b1;
                end
            end

            trle_pkg::PH_PIXELS: begin
                final_index = n_alpha_present ? 2'd3 : 2'd2;
                if (n_rle_mode && (n_packet_left == 8'd0)) begin
                    // Packet header: run flag and count minus one
                    n_packet_is_run = b[trle_pkg::PKT_RUN_BIT];
                    n_packet_left   = (b & trle_pkg::PKT_CNT_MASK) + 8'd1;
                    n_byte_in_pixel = '0;
                end else if (n_byte_in_pixel < final_index) begin
                    // Collect B, G (and R for 32-bit) bytes
                    unique case (n_byte_in_pixel)
                        2'd0:    n_partial_color[7:0]   = n_partial_color[7:0]   | b;
                        2'd1:    n_partial_color[15:8]  = n_partial_color[15:8]  | b;
                        default: n_partial_color[23:16] = n_partial_color[23:16] | b;
                    endcase
                    n_byte_in_pixel = n_byte_in_pixel + 2'd1;
                end else begin
                    if (n_alpha_present) begin
                        rgba = {n_partial_color[23:16], n_partial_color[15:8],
                                n_partial_color[7:0], b};
                    end else begin
                        rgba = {b, n_partial_color[15:8], n_partial_color[7:0],
                                trle_pkg::ALPHA_OPAQUE};
                    end
                    n_byte_in_pixel = '0;
                    n_partial_color = '0;
                    res_valid       = 1'b1;
                    res_row         = pos.dest_row;
                    res_col         = r_column_count;
                    res_rgba        = rgba;
                    res_last        = pos.last;
                    if (pos.last) begin
                        n_phase = trle_pkg::PH_DONE;
                    end else begin
                        n_column_count = pos.next_col;
                        n_row_count    = pos.next_row;
                    end
                    if (n_rle_mode) begin
                        n_packet_left = n_packet_left - 8'd1;
                        // Repeat the color on the following items
                        if (!pos.last && n_packet_is_run && (n_packet_left != 8'd0)) begin
                            n_run_color = rgba;
                            n_phase     = trle_pkg::PH_RUN;
                        end
                    end
                end
            end

            trle_pkg::PH_RUN: begin
                n_packet_left = n_packet_left - 8'd1;
                res_valid     = 1'b1;
                res_row       = pos.dest_row;
                res_col       = r_column_count;
                res_rgba      = n_run_color;
                res_last      = pos.last;
                if (pos.last) begin
                    n_phase = trle_pkg::PH_DONE;
                end else begin
                    n_column_count = pos.next_col;
                    n_row_count    = pos.next_row;
                    if (n_packet_left == 8'd0) begin
                        n_phase = trle_pkg::PH_PIXELS;
                    end
                end
            end

            trle_pkg::PH_DONE: begin
            end

            default: begin
                n_phase = trle_pkg::PH_DONE;
            end
        endcase

        // Enter pixel data; an empty image goes straight to done
        if (start_pixels) begin
            if ((n_image_width == 16'd0) || (n_image_height == 16'd0)) begin
                n_phase = trle_pkg::PH_DONE;
            end else begin
                n_phase         = trle_pkg::PH_PIXELS;
                n_column_count  = '0;
                n_row_count     = n_rle_mode ? (n_image_height - 16'd1) : 16'd0;
                n_packet_left   = '0;
                n_packet_is_run = 1'b0;
                n_byte_in_pixel = '0;
                n_partial_color = '0;
            end
        end
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= trle_pkg::PH_HEADER;
            r_header_index  <= '0;
            r_id_skip_left  <= '0;
            r_image_width   <= '0;
            r_image_height  <= '0;
            r_rle_mode      <= 1'b0;
            r_alpha_present <= 1'b0;
            r_flip_rows     <= 1'b0;
            r_packet_left   <= '0;
            r_packet_is_run <= 1'b0;
            r_byte_in_pixel <= '0;
            r_partial_color <= '0;
            r_run_color     <= '0;
            r_column_count  <= '0;
            r_row_count     <= '0;
        end else if (in_fire) begin
            r_phase         <= n_phase;
            r_header_index  <= n_header_index;
            r_id_skip_left  <= n_id_skip_left;
            r_image_width   <= n_image_width;
            r_image_height  <= n_image_height;
            r_rle_mode      <= n_rle_mode;
            r_alpha_present <= n_alpha_present;
            r_flip_rows     <= n_flip_rows;
            r_packet_left   <= n_packet_left;
            r_packet_is_run <= n_packet_is_run;
            r_byte_in_pixel <= n_byte_in_pixel;
            r_partial_color <= n_partial_color;
            r_run_color     <= n_run_color;
            r_column_count  <= n_column_count;
            r_row_count     <= n_row_count;
        end
    end

    // Output register: load a new result, or drain when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_fire && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && res_valid) begin
            r_out_data   <= {res_rgba[7:0], res_rgba[15:8], res_rgba[23:16],
                             res_rgba[31:24], res_col, res_row};
            r_out_status <= res_status;
            r_out_last   <= res_last;
        end
    end

endmodule

@@ src/trle_pixel_pos.sv @@
// ----------------------------------------------------------------------------
// TGA RLE decoder pixel position
// Destination row, end-of-image flag and next scan position for one pixel.
// ----------------------------------------------------------------------------
module trle_pixel_pos (
    input  logic          [15:0] i_col,
    input  logic          [15:0] i_row,
    input  logic          [15:0] i_width,
    input  logic          [15:0] i_height,
    input  logic                 i_rle,
    input  logic                 i_flip,
    output trle_pkg::t_pos       o_pos
);

    logic [16:0] col_inc;
    logic [16:0] row_inc;
    logic [15:0] height_m1;
    logic        end_col;
    logic        end_row;

    assign col_inc   = {1'b0, i_col} + 17'd1;
    assign row_inc   = {1'b0, i_row} + 17'd1;
    assign height_m1 = i_height - 16'd1;
    assign end_col   = (col_inc == {1'b0, i_width});
    // raw rows ascend, RLE rows descend
    assign end_row   = i_rle ? (i_row == 16'd0) : (row_inc == {1'b0, i_height});

    always_comb begin
        o_pos.dest_row = i_flip ? (height_m1 - i_row) : i_row;
        o_pos.last     = end_col && end_row;
        o_pos.next_col = end_col ? 16'd0 : col_inc[15:0];
        if (end_col) begin
            o_pos.next_row = i_rle ? (i_row - 16'd1) : row_inc[15:0];
        end else begin
            o_pos.next_row = i_row;
        end
    end

endmodule
